>>> hw/rtl/crc32_word_serial_defines.svh
// assertion macros used by the crc32 word-serial core
`ifndef CRC32_WORD_SERIAL_DEFINES_SVH
`define CRC32_WORD_SERIAL_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CRC32WS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crc32ws assertion failed");

// antecedent implies consequent in the next cycle
`define CRC32WS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crc32ws assertion failed");

`endif

>>> hw/rtl/crc32ws_pkg.sv
// types, constants and the word-advance function for the crc32 word-serial block
`timescale 1ns / 1ps

package crc32ws_pkg;

    typedef logic [31:0] t_word;
    typedef logic [31:0][31:0] t_col_tbl;

    // control bits of the transaction held in the input register
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_stage_ctl;

    localparam t_word CRC_POLY = 32'h04C1_1DB7;
    localparam t_word CRC_INIT = 32'hFFFF_FFFF;

    // column i is the remainder of x^(i+32) modulo the polynomial
    function automatic t_col_tbl build_cols();
        t_col_tbl tbl;
        t_word    c;
        c = CRC_POLY;
        for (int i = 0; i < 32; i++) begin
            tbl[i] = c;
            c = {c[30:0], 1'b0} ^ (c[31] ? CRC_POLY : 32'h0);
        end
        return tbl;
    endfunction

    localparam t_col_tbl CRC_COLS = build_cols();

    // crc after absorbing one word msb first equals the crc of (crc ^ word) shifted by 32 zeros
    function automatic t_word crc_advance(t_word crc, t_word word);
        t_word v;
        t_word acc;
        v   = crc ^ word;
        acc = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                acc = acc ^ CRC_COLS[i];
            end
        end
        return acc;
    endfunction

endpackage

>>> hw/rtl/crc32ws_in_reg.sv
// input register stage of the crc32 word-serial block
`timescale 1ns / 1ps

module crc32ws_in_reg (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [31:0]             i_data_word,
    input  logic                    i_first_word,
    input  logic                    i_last_word,
    input  logic                    i_take,
    output crc32ws_pkg::t_stage_ctl o_ctl,
    output crc32ws_pkg::t_word      o_data
);

    logic               r_valid;
    logic               n_valid;
    logic               r_first;
    logic               r_last;
    crc32ws_pkg::t_word r_data;
    logic               in_fire;

    // stage frees up in the same cycle its transaction moves on
    assign o_in_ready = !r_valid || i_take;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_valid = r_valid;
        if (in_fire) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_data  <= i_data_word;
            r_first <= i_first_word;
            r_last  <= i_last_word;
        end
    end

    assign o_ctl.valid = r_valid;
    assign o_ctl.first = r_first;
    assign o_ctl.last  = r_last;
    assign o_data      = r_data;

endmodule

>>> hw/rtl/crc32ws_core.sv
// crc state register, word update network and result register
`timescale 1ns / 1ps
`include "crc32_word_serial_defines.svh"

module crc32ws_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  crc32ws_pkg::t_stage_ctl i_ctl,
    input  crc32ws_pkg::t_word      i_data,
    output logic                    o_take,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [31:0]             o_checksum
);

    crc32ws_pkg::t_word r_crc;
    crc32ws_pkg::t_word n_crc;
    crc32ws_pkg::t_word crc_base;
    logic               r_out_valid;
    logic               n_out_valid;
    crc32ws_pkg::t_word r_checksum;
    logic               out_free;

    assign out_free = !r_out_valid || i_out_ready;
    // a word without the last flag never needs the result slot
    assign o_take   = i_ctl.valid && (out_free || !i_ctl.last);

    assign crc_base = i_ctl.first ? crc32ws_pkg::CRC_INIT : r_crc;
    assign n_crc    = crc32ws_pkg::crc_advance(crc_base, i_data);

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_take && i_ctl.last) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= crc32ws_pkg::CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_take) begin
                r_crc <= n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_ctl.last) begin
            r_checksum <= n_crc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_checksum  = r_checksum;

    `CRC32WS_ASSERT_NEXT(a_last_gives_result, i_clk, i_rst_n, o_take && i_ctl.last,
        r_out_valid && r_checksum == r_crc)
    `CRC32WS_ASSERT_NEXT(a_crc_holds_when_idle, i_clk, i_rst_n, !o_take, $stable(r_crc))
    `CRC32WS_ASSERT_NEXT(a_first_restarts, i_clk, i_rst_n, o_take && i_ctl.first,
        r_crc == crc32ws_pkg::crc_advance(crc32ws_pkg::CRC_INIT, $past(i_data)))
    `CRC32WS_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, o_take && i_ctl.last,
        !r_out_valid || i_out_ready)

endmodule

>>> hw/rtl/crc32_word_serial.sv
// top level of the word-serial crc-32/mpeg-2 checksum block
// update: the 32-bit xor network loads the crc register when the core takes a word; on a
//   last word the checksum and its valid flag are loaded at that same edge
// throughput: one word per cycle, except while a last word waits for a full result slot
// reset: synchronous active-low i_rst_n presets the crc to all ones and empties both stages
`timescale 1ns / 1ps

module crc32_word_serial (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_data_word,
    input  logic        i_first_word,
    input  logic        i_last_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_checksum
);

    crc32ws_pkg::t_stage_ctl stage_ctl;
    crc32ws_pkg::t_word      stage_data;
    logic                    stage_take;

    crc32ws_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_word  (i_data_word),
        .i_first_word (i_first_word),
        .i_last_word  (i_last_word),
        .i_take       (stage_take),
        .o_ctl        (stage_ctl),
        .o_data       (stage_data)
    );

    crc32ws_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (stage_ctl),
        .i_data      (stage_data),
        .o_take      (stage_take),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_checksum  (o_checksum)
    );

endmodule

>>> tb/tb_crc32_word_serial.sv
// self-checking testbench for the word-serial crc-32/mpeg-2 checksum block
`timescale 1ns / 1ps

module tb_crc32_word_serial;

    typedef crc32ws_pkg::t_word t_word;

    localparam t_word GEN_POLY   = 32'h04C1_1DB7;
    localparam t_word PRESET     = 32'hFFFF_FFFF;
    localparam t_word MSB_MASK   = 32'h8000_0000;
    localparam int    WORDS_PER_PHASE = 360;
    localparam int    WATCHDOG_LIMIT  = 5000;
    localparam int    DRAIN_CYCLES    = 8;
    localparam int    MAX_REPORTS     = 10;

    typedef struct {
        t_word word;
        logic  first;
        logic  last;
        logic  typed;    // checksum below is fixed rather than predicted
        t_word chk;
    } t_dir_row;

    localparam int N_DIR = 18;

    t_dir_row dir_tbl [N_DIR] = '{
        // register comes out of reset preset: all-ones word cancels it
        '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, 32'h0000_0000},
        // single-word message, all ones
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'h0000_0000},
        // no re-preset after a last word: zero register absorbs zero word
        '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'h0000_0000},
        '{32'h0000_0000, 1'b1, 1'b1, 1'b0, '0},
        '{32'h8000_0000, 1'b1, 1'b0, 1'b0, '0},
        '{32'h0000_0001, 1'b0, 1'b0, 1'b0, '0},
        '{32'hAAAA_AAAA, 1'b0, 1'b1, 1'b0, '0},
        // first flag in the middle of a message restarts it
        '{32'h5555_5555, 1'b1, 1'b0, 1'b0, '0},
        '{32'h1234_5678, 1'b1, 1'b1, 1'b0, '0},
        '{32'hDEAD_BEEF, 1'b1, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b0, 1'b0, 1'b0, '0},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, '0},
        '{32'h0F0F_0F0F, 1'b0, 1'b1, 1'b0, '0},
        // words with no flags keep running on the old register
        '{32'hF0F0_F0F0, 1'b0, 1'b0, 1'b0, '0},
        '{32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0, '0},
        '{32'h8000_0001, 1'b1, 1'b1, 1'b0, '0},
        '{32'hFFFF_FFFE, 1'b1, 1'b0, 1'b0, '0},
        '{32'h0000_0000, 1'b0, 1'b1, 1'b0, '0}
    };

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic [31:0] i_data_word  = '0;
    logic        i_first_word = 1'b0;
    logic        i_last_word  = 1'b0;
    logic        i_out_ready  = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_checksum;

    t_word crc_state;
    t_word checksum_q [$];
    int    idle_pct     = 0;
    int    stall_pct    = 0;
    int    n_words      = 0;
    int    n_messages   = 0;
    int    n_checked    = 0;
    int    n_errors     = 0;
    int    idle_cycles  = 0;

    crc32_word_serial dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_word  (i_data_word),
        .i_first_word (i_first_word),
        .i_last_word  (i_last_word),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_checksum   (o_checksum)
    );

    always #10 i_clk = ~i_clk;

    // one bit per step, msb first: feedback is register top xor data bit
    function automatic t_word crc_absorb(input t_word crc, input t_word word);
        logic fb;
        for (int k = 0; k < 32; k++) begin
            fb   = ((crc ^ word) & MSB_MASK) != 0;
            crc  = crc << 1;
            word = word << 1;
            if (fb) begin
                crc = crc ^ GEN_POLY;
            end
        end
        return crc;
    endfunction

    function automatic t_word pick_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(31);
            3: return ~(32'h1 << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    // present one word, wait for the transaction, then update the prediction
    task automatic send_word(input t_word word, input logic first, input logic last,
                             input logic typed, input t_word fixed_chk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_word  <= word;
        i_first_word <= first;
        i_last_word  <= last;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        n_words++;
        if (first) begin
            crc_state = PRESET;
        end
        crc_state = crc_absorb(crc_state, word);
        if (last) begin
            n_messages++;
            checksum_q.push_back(typed ? fixed_chk : crc_state);
        end
    endtask

    task automatic send_message();
        int len;
        bit noisy;
        noisy = ($urandom_range(99) < 15);
        len   = ($urandom_range(19) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
            if (noisy) begin
                send_word(pick_word(), 1'($urandom_range(1)), 1'($urandom_range(1)),
                          1'b0, '0);
            end else begin
                send_word(pick_word(), k == 0, k == len - 1, 1'b0, '0);
            end
        end
    endtask

    task automatic report_fail(input t_word want, input t_word got, input bit orphan);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            if (orphan) begin
                $display("mismatch: checksum %08h with nothing expected", got);
            end else begin
                $display("mismatch: checksum expected %08h, got %08h", want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // result checking and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
            if (o_out_valid && i_out_ready) begin
                n_checked++;
                if (checksum_q.size() == 0) begin
                    report_fail('0, o_checksum, 1'b1);
                end else begin
                    if (o_checksum !== checksum_q[0]) begin
                        report_fail(checksum_q[0], o_checksum, 1'b0);
                    end
                    void'(checksum_q.pop_front());
                end
            end
        end
    end

    initial begin
        crc_state = PRESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            send_word(dir_tbl[r].word, dir_tbl[r].first, dir_tbl[r].last,
                      dir_tbl[r].typed, dir_tbl[r].chk);
        end

        // four pressure mixes: none, sender idle, receiver stall, both light
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 67; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 67; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            while (n_words < N_DIR + (ph + 1) * WORDS_PER_PHASE) begin
                send_message();
            end
        end

        i_in_valid <= 1'b0;
        while (checksum_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d words in %0d terminated messages, checked %0d checksums",
                 n_words, n_messages, n_checked);
        $display("stimulus: directed edge words, framed and unframed streams, four idle mixes");
        if (n_errors == 0 && checksum_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d checksums never arrived", n_errors, checksum_q.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
